// File: sv/pte_pkg.sv
// Shared types and constants for the page table engine.
package pte_pkg;

	// Table geometry
	localparam int PAGES    = 256;
	localparam int PAGE_W   = $clog2(PAGES);
	localparam int SCAN_W   = PAGE_W + 1;
	localparam int COUNT_W  = $clog2(PAGES + 1);
	localparam int FRAME_W  = 10;
	localparam int ENTRY_W  = FRAME_W + 4;
	localparam int PAGEIN_W = 8;
	localparam int REQ_W    = 3;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 32;

	// Request codes carried on the input tuser
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD     = 3'd0,
		REQ_REMOVE  = 3'd1,
		REQ_LOOKUP  = 3'd2,
		REQ_SET_REF = 3'd3,
		REQ_SET_MOD = 3'd4,
		REQ_INVAL   = 3'd5,
		REQ_CLEAR   = 3'd6
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		STS_OK          = 2'd0,
		STS_ALREADY     = 2'd1,
		STS_UNMAPPED    = 2'd2,
		STS_NOT_PRESENT = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_WIPE,
		ST_RESP
	} state_t;

	// One table entry as held in the table memory
	typedef struct packed {
		logic               mapped;
		logic               present;
		logic               referenced;
		logic               modified;
		logic [FRAME_W-1:0] frame;
	} entry_t;

endpackage

// File: sv/pte_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/page_table_engine.sv
// Top level of the page table engine: sequencer, table memory and counters.
//
//  channel | dir | signals                         | contents
//  s       | in  | s_tvalid s_tready s_tdata s_tuser | one request
//  m       | out | m_tvalid m_tready m_tdata       | one result per request
//
//  Add, remove, lookup, flag writes and unused codes: the accept
//  cycle reads the table entry, the next writes it back where the request changes it and loads the result.
//  Invalidate walks the table one entry a cycle.
//  Clear wipes the table one entry a cycle.
//  After reset the table is wiped before the first request is taken.
//  A stalled result register holds the engine in the response state; no request is taken meanwhile.
module page_table_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// page_index [7:0], frame_in [17:8], flag_value [18], zero [23:19]
	input  logic [pte_pkg::IN_W-1:0]   s_tdata,
	// req_type [2:0]
	input  logic [pte_pkg::REQ_W-1:0]  s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status [1:0], page_present [2], frame_out [12:3],
	// present_total [21:13], modified_total [30:22], zero [31]
	output logic [pte_pkg::OUT_W-1:0]  m_tdata
);

	// Sequencer and request registers
	pte_pkg::state_t                   state_q, state_d;
	pte_pkg::req_t                     req_q;
	logic [pte_pkg::PAGE_W-1:0]        idx_q;
	logic                              in_range_q;
	logic [pte_pkg::FRAME_W-1:0]       frame_q;
	logic                              flag_q;

	// Counters
	logic [pte_pkg::COUNT_W-1:0]       pcnt_q, pcnt_d, mcnt_q, mcnt_d;

	// Scan counter and check stage
	logic [pte_pkg::SCAN_W-1:0]        scan_q;
	logic                              scan_issue;
	logic                              wipe_last;
	logic                              chk_valid_s1;
	logic [pte_pkg::PAGE_W-1:0]        chk_idx_s1;

	// Table memory port
	logic                              ram_we;
	logic [pte_pkg::PAGE_W-1:0]        ram_waddr;
	logic [pte_pkg::ENTRY_W-1:0]       ram_wdata;
	logic [pte_pkg::PAGE_W-1:0]        ram_raddr;
	logic [pte_pkg::ENTRY_W-1:0]       ram_rdata;
	pte_pkg::entry_t                   rd, wr;

	// Held and fresh result fields
	pte_pkg::status_t                  res_status_q, res_status_d;
	logic                              res_present_q, res_present_d;
	logic [pte_pkg::FRAME_W-1:0]       res_frame_q, res_frame_d;
	logic                              res_load;

	// Output register
	logic                              m_tvalid_q;
	logic [pte_pkg::OUT_W-1:0]         m_tdata_q, out_data_d;
	logic                              out_load, out_free;

	// Input decode
	logic                              s_accept;
	logic [pte_pkg::PAGE_W-1:0]        s_idx;
	logic                              s_in_range;
	logic                              cur_m, cur_p, cur_mod;

	assign s_accept   = s_tvalid && s_tready;
	assign s_idx      = pte_pkg::PAGE_W'(s_tdata[pte_pkg::PAGEIN_W-1:0]);
	assign s_in_range = 32'(s_tdata[pte_pkg::PAGEIN_W-1:0]) < 32'(pte_pkg::PAGES);
	assign out_free   = !m_tvalid_q || m_tready;
	assign rd         = pte_pkg::entry_t'(ram_rdata);
	assign ram_wdata  = wr;
	assign cur_m      = in_range_q && rd.mapped;
	assign cur_p      = rd.present;
	assign cur_mod    = rd.modified;
	assign wipe_last  = scan_q == pte_pkg::SCAN_W'(pte_pkg::PAGES - 1);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;

	pte_ram #(
		.WIDTH (pte_pkg::ENTRY_W),
		.DEPTH (pte_pkg::PAGES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pte_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, table updates and result selection
	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		ram_raddr     = s_idx;
		ram_we        = 1'b0;
		ram_waddr     = idx_q;
		wr            = '0;
		pcnt_d        = pcnt_q;
		mcnt_d        = mcnt_q;
		scan_issue    = 1'b0;
		res_status_d  = pte_pkg::STS_OK;
		res_present_d = 1'b0;
		res_frame_d   = '0;
		res_load      = 1'b0;
		out_load      = 1'b0;
		out_data_d    = '0;
		unique case (state_q)
			pte_pkg::ST_INIT: begin
				// After reset, wipe one entry a cycle
				ram_we    = 1'b1;
				ram_waddr = scan_q[pte_pkg::PAGE_W-1:0];
				if (wipe_last) begin
					state_d = pte_pkg::ST_IDLE;
				end
			end
			pte_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					priority if (pte_pkg::req_t'(s_tuser) == pte_pkg::REQ_INVAL) begin
						state_d = pte_pkg::ST_SCAN;
					end else if (pte_pkg::req_t'(s_tuser) == pte_pkg::REQ_CLEAR) begin
						state_d = pte_pkg::ST_WIPE;
					end else begin
						state_d = pte_pkg::ST_EXEC;
					end
				end
			end
			pte_pkg::ST_EXEC: begin
				unique case (req_q)
					pte_pkg::REQ_ADD: begin
						if (!in_range_q) begin
							res_status_d = pte_pkg::STS_UNMAPPED;
						end else if (rd.mapped) begin
							res_status_d = pte_pkg::STS_ALREADY;
						end else begin
							wr     = '{mapped: 1'b1, present: 1'b1, referenced: 1'b0,
								modified: 1'b0, frame: frame_q};
							ram_we = 1'b1;
							pcnt_d = pcnt_q + 1'b1;
						end
					end
					pte_pkg::REQ_REMOVE: begin
						if (!cur_m) begin
							res_status_d = pte_pkg::STS_UNMAPPED;
						end else begin
							ram_we = 1'b1;
							if (cur_p) begin
								pcnt_d = pcnt_q - 1'b1;
								if (cur_mod) begin
									mcnt_d = mcnt_q - 1'b1;
								end
							end
						end
					end
					pte_pkg::REQ_LOOKUP: begin
						if (!cur_m) begin
							res_status_d = pte_pkg::STS_UNMAPPED;
						end else if (!cur_p) begin
							res_status_d = pte_pkg::STS_NOT_PRESENT;
						end else begin
							res_present_d = 1'b1;
							res_frame_d   = rd.frame;
						end
					end
					pte_pkg::REQ_SET_REF: begin
						if (!cur_m) begin
							res_status_d = pte_pkg::STS_UNMAPPED;
						end else begin
							wr            = rd;
							wr.referenced = flag_q;
							ram_we        = 1'b1;
						end
					end
					pte_pkg::REQ_SET_MOD: begin
						if (!cur_m) begin
							res_status_d = pte_pkg::STS_UNMAPPED;
						end else begin
							wr          = rd;
							wr.modified = flag_q;
							ram_we      = 1'b1;
							if (cur_p && (cur_mod != flag_q)) begin
								mcnt_d = flag_q ? mcnt_q + 1'b1 : mcnt_q - 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
				// Load the result now if the output register is free, else hold it
				res_load = 1'b1;
				if (out_free) begin
					out_load   = 1'b1;
					out_data_d = pte_pkg::OUT_W'({mcnt_d, pcnt_d, res_frame_d,
						res_present_d, res_status_d});
					state_d    = pte_pkg::ST_IDLE;
				end else begin
					state_d = pte_pkg::ST_RESP;
				end
			end
			pte_pkg::ST_SCAN: begin
				ram_raddr  = scan_q[pte_pkg::PAGE_W-1:0];
				ram_waddr  = chk_idx_s1;
				scan_issue = scan_q < pte_pkg::SCAN_W'(pte_pkg::PAGES);
				// Drop a present entry whose frame matches
				if (chk_valid_s1 && rd.mapped && rd.present && (rd.frame == frame_q)) begin
					wr            = rd;
					wr.present    = 1'b0;
					wr.referenced = 1'b0;
					wr.modified   = 1'b0;
					ram_we        = 1'b1;
					pcnt_d        = pcnt_q - 1'b1;
					if (rd.modified) begin
						mcnt_d = mcnt_q - 1'b1;
					end
				end
				if (!scan_issue && !chk_valid_s1) begin
					res_load = 1'b1;
					state_d  = pte_pkg::ST_RESP;
				end
			end
			pte_pkg::ST_WIPE: begin
				// Wipe one entry a cycle and zero both counts
				ram_we    = 1'b1;
				ram_waddr = scan_q[pte_pkg::PAGE_W-1:0];
				pcnt_d    = '0;
				mcnt_d    = '0;
				if (wipe_last) begin
					res_load = 1'b1;
					state_d  = pte_pkg::ST_RESP;
				end
			end
			pte_pkg::ST_RESP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_data_d = pte_pkg::OUT_W'({mcnt_q, pcnt_q, res_frame_q,
						res_present_q, res_status_q});
					state_d    = pte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pte_pkg::ST_IDLE;
			end
		endcase
	end

	// Capture the request, the held result and the scan check index
	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_q      <= pte_pkg::req_t'(s_tuser);
			idx_q      <= s_idx;
			in_range_q <= s_in_range;
			frame_q    <= s_tdata[pte_pkg::PAGEIN_W +: pte_pkg::FRAME_W];
			flag_q     <= s_tdata[pte_pkg::PAGEIN_W + pte_pkg::FRAME_W];
		end
		if (res_load) begin
			res_status_q  <= res_status_d;
			res_present_q <= res_present_d;
			res_frame_q   <= res_frame_d;
		end
		if (state_q == pte_pkg::ST_SCAN) begin
			chk_idx_s1 <= scan_q[pte_pkg::PAGE_W-1:0];
		end
	end

	// Advance the scan, its check stage and the wipe pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			chk_valid_s1 <= 1'b0;
		end else if (s_accept) begin
			scan_q       <= '0;
			chk_valid_s1 <= 1'b0;
		end else if (state_q == pte_pkg::ST_SCAN) begin
			scan_q       <= scan_q + pte_pkg::SCAN_W'(scan_issue);
			chk_valid_s1 <= scan_issue;
		end else if (state_q == pte_pkg::ST_INIT || state_q == pte_pkg::ST_WIPE) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	// Update the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			mcnt_q <= '0;
		end else begin
			pcnt_q <= pcnt_d;
			mcnt_q <= mcnt_d;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= out_data_d;
		end
	end

endmodule

// File: sv/pte_checker.sv
// Port-level checks for the page table engine, bound to the top level.
module pte_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [pte_pkg::IN_W-1:0]   s_tdata,
	input  logic [pte_pkg::REQ_W-1:0]  s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [pte_pkg::OUT_W-1:0]  m_tdata
);

	// A request is served alone: no second one in the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while the previous one was still in work");

	// A stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// A present page is reported only with status ok
	a_present_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == pte_pkg::STS_OK)
		else $error("page reported present with a failing status");

	// Frame is zero unless the page is reported present
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[12:3] == '0)
		else $error("frame given for a page not reported present");

	// Modified count never exceeds present count
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[30:22] <= m_tdata[21:13])
		else $error("modified count above present count");

endmodule

bind page_table_engine pte_checker u_pte_checker (.*);
